FILE: rtl/core/psfp_pkg.sv
package psfp_pkg;

    // Default frame store depth in bytes
    localparam int BUF_DEPTH_DEF = 64;

    // Frame header pair
    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;

    // Output word layout
    localparam int         WORD_COUNT = 14;
    localparam logic [3:0] LAST_IDX   = 4'(WORD_COUNT - 1);
    localparam int         WORD_BASE  = 4;
    localparam int         CK_POS     = WORD_BASE + 2 * (WORD_COUNT - 1);

    // Length field plus offset, one bit wider than the field
    localparam int LEN_W = 17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HDR2,
        S_SUM,
        S_CK_HI,
        S_CK_LO,
        S_CK_CMP,
        S_W_HI,
        S_W_LO,
        S_W_OUT
    } state_t;

endpackage

FILE: rtl/core/psfp_if.sv
// Received byte channel
interface psfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded word channel
interface psfp_word_if;
    logic        valid;
    logic        ready;
    logic [3:0]  word_index;
    logic [15:0] word_value;
    logic        checksum_ok;
    logic        last_word;

    modport source (output valid, output word_index, output word_value,
                    output checksum_ok, output last_word, input ready);
    modport sink (input valid, input word_index, input word_value,
                  input checksum_ok, input last_word, output ready);
endinterface

FILE: rtl/core/psfp_store.sv
// Frame byte store: one write port, one registered read port.
// Entries not yet written since reset read as zero.
module psfp_store #(
    parameter int BUF_DEPTH = psfp_pkg::BUF_DEPTH_DEF,
    localparam int AW = $clog2(BUF_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]           mem [BUF_DEPTH];
    logic [BUF_DEPTH-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 vld_q_reg;

    // Storage array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Written flags, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : 8'h00;

endmodule

FILE: rtl/core/particulate_sensor_frame_parser_top.sv
// Particulate sensor frame parser.
// Input channel "bytes" takes one received serial byte per transaction; output
// channel "words" delivers the 14 big-endian words of each good frame (bytes
// 4..31), word 13 being the sensor checksum, each flagged with checksum_ok.
// A byte pair 0x42 0x4D restarts the frame; a frame completes when the byte
// count reaches the length field plus 4. Frames with a bad header give nothing.
// In idle an ordinary byte goes straight into the store; the second header byte
// holds off input while byte 0 and byte 1 are written in turn through the single
// store write port. A byte that completes a good frame holds off input while the
// frame is read back: one store read per cycle feeds the byte-sum adder, then the
// checksum is read and compared, then each word's two bytes pass the read port.
// Results sit in an output register, so input is taken again as soon as the
// last word is loaded; a stalled receiver freezes the word sequencer.
// Reset clears the count, the last byte and the store contents (the store
// keeps one written flag per byte, so no clearing pass is needed).
module particulate_sensor_frame_parser_top #(
    parameter int BUF_DEPTH = psfp_pkg::BUF_DEPTH_DEF
) (
    input logic          clk,
    input logic          rst_n,
    psfp_byte_if.sink    bytes,
    psfp_word_if.source  words
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int CW = $clog2(BUF_DEPTH + 1);
    localparam int LEN_BITS = psfp_pkg::LEN_W;

    psfp_pkg::state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    prev_reg, prev_next;
    logic [7:0]    pend_reg, pend_next;
    logic [7:0]    hdr0_reg, hdr0_next;
    logic [7:0]    hdr1_reg, hdr1_next;
    logic [7:0]    len_hi_reg, len_hi_next;
    logic [7:0]    len_lo_reg, len_lo_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] last_reg, last_next;
    logic          acc_reg, acc_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    hi_reg, hi_next;
    logic          ok_reg, ok_next;
    logic [3:0]    word_reg, word_next;

    logic          out_valid_reg, out_valid_next;
    logic [3:0]    out_index_reg, out_index_next;
    logic [15:0]   out_value_reg, out_value_next;
    logic          out_ok_reg, out_ok_next;
    logic          out_last_reg, out_last_next;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;

    logic [CW-1:0]    base_cnt;
    logic [AW-1:0]    base_addr;
    logic [CW-1:0]    cnt_inc;
    logic [7:0]       len_hi_new;
    logic [7:0]       len_lo_new;
    logic [LEN_BITS-1:0] len_ext;
    logic [LEN_BITS-1:0] span;
    logic             hdr_pair;
    logic             frame_done;
    logic             hdr_ok;
    logic [AW-1:0]    word_addr;
    logic             load_out;

    psfp_store #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Byte position bookkeeping for the incoming byte
    always_comb
    begin
        base_cnt   = (count_reg >= CW'(BUF_DEPTH)) ? '0 : count_reg;
        base_addr  = base_cnt[AW-1:0];
        cnt_inc    = base_cnt + CW'(1);
        len_hi_new = (base_addr == AW'(2)) ? bytes.rx_byte : len_hi_reg;
        len_lo_new = (base_addr == AW'(3)) ? bytes.rx_byte : len_lo_reg;
        len_ext    = {1'b0, len_hi_new, len_lo_new};
        span       = len_ext + LEN_BITS'(2);
        hdr_pair   = (prev_reg == psfp_pkg::HDR_FIRST) &&
                     (bytes.rx_byte == psfp_pkg::HDR_SECOND);
        frame_done = (cnt_inc > CW'(3)) &&
                     ((len_ext + LEN_BITS'(4)) == LEN_BITS'(cnt_inc));
        hdr_ok     = (hdr0_reg == psfp_pkg::HDR_FIRST) &&
                     (hdr1_reg == psfp_pkg::HDR_SECOND);
        word_addr  = AW'(psfp_pkg::WORD_BASE) + AW'({word_reg, 1'b0});
    end

    // Sequencer: next state, store access and output load
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        prev_next   = prev_reg;
        pend_next   = pend_reg;
        hdr0_next   = hdr0_reg;
        hdr1_next   = hdr1_reg;
        len_hi_next = len_hi_reg;
        len_lo_next = len_lo_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        acc_next    = 1'b0;
        sum_next    = sum_reg;
        hi_next     = hi_reg;
        ok_next     = ok_reg;
        word_next   = word_reg;
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = 8'h00;
        rd_addr     = '0;
        load_out    = 1'b0;

        // Byte sum, one read behind the address
        if (acc_reg)
        begin
            sum_next = sum_reg + {8'h00, rd_data};
        end

        case (state_reg)
            psfp_pkg::S_IDLE:
            begin
                if (bytes.valid)
                begin
                    prev_next = bytes.rx_byte;
                    wr_en     = 1'b1;
                    if (hdr_pair)
                    begin
                        // Restart: byte 0 now, byte 1 next cycle
                        wr_addr    = '0;
                        wr_data    = psfp_pkg::HDR_FIRST;
                        hdr0_next  = psfp_pkg::HDR_FIRST;
                        pend_next  = bytes.rx_byte;
                        state_next = psfp_pkg::S_HDR2;
                    end
                    else
                    begin
                        wr_addr     = base_addr;
                        wr_data     = bytes.rx_byte;
                        len_hi_next = len_hi_new;
                        len_lo_next = len_lo_new;
                        if (base_addr == AW'(0))
                        begin
                            hdr0_next = bytes.rx_byte;
                        end
                        if (base_addr == AW'(1))
                        begin
                            hdr1_next = bytes.rx_byte;
                        end
                        if (frame_done)
                        begin
                            count_next = '0;
                            if (hdr_ok)
                            begin
                                sum_next   = 16'h0000;
                                idx_next   = '0;
                                last_next  = (span >= LEN_BITS'(BUF_DEPTH)) ?
                                             AW'(BUF_DEPTH - 1) :
                                             AW'(span - LEN_BITS'(1));
                                state_next = psfp_pkg::S_SUM;
                            end
                        end
                        else
                        begin
                            count_next = cnt_inc;
                        end
                    end
                end
            end

            psfp_pkg::S_HDR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = AW'(1);
                wr_data    = pend_reg;
                hdr1_next  = pend_reg;
                count_next = CW'(2);
                state_next = psfp_pkg::S_IDLE;
            end

            psfp_pkg::S_SUM:
            begin
                rd_addr  = idx_reg;
                acc_next = 1'b1;
                if (idx_reg == last_reg)
                begin
                    state_next = psfp_pkg::S_CK_HI;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end

            psfp_pkg::S_CK_HI:
            begin
                rd_addr    = AW'(psfp_pkg::CK_POS);
                state_next = psfp_pkg::S_CK_LO;
            end

            psfp_pkg::S_CK_LO:
            begin
                rd_addr    = AW'(psfp_pkg::CK_POS + 1);
                hi_next    = rd_data;
                state_next = psfp_pkg::S_CK_CMP;
            end

            psfp_pkg::S_CK_CMP:
            begin
                ok_next    = ({hi_reg, rd_data} == sum_reg);
                word_next  = '0;
                state_next = psfp_pkg::S_W_HI;
            end

            psfp_pkg::S_W_HI:
            begin
                rd_addr    = word_addr;
                state_next = psfp_pkg::S_W_LO;
            end

            psfp_pkg::S_W_LO:
            begin
                rd_addr    = word_addr + AW'(1);
                hi_next    = rd_data;
                state_next = psfp_pkg::S_W_OUT;
            end

            psfp_pkg::S_W_OUT:
            begin
                // Keep the low byte address so the read data holds on a stall
                rd_addr = word_addr + AW'(1);
                if (!out_valid_reg || words.ready)
                begin
                    load_out = 1'b1;
                    if (word_reg == psfp_pkg::LAST_IDX)
                    begin
                        state_next = psfp_pkg::S_IDLE;
                    end
                    else
                    begin
                        word_next  = word_reg + 4'd1;
                        state_next = psfp_pkg::S_W_HI;
                    end
                end
            end

            default:
            begin
                state_next = psfp_pkg::S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !words.ready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_ok_next    = out_ok_reg;
        out_last_next  = out_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_index_next = word_reg;
            out_value_next = {hi_reg, rd_data};
            out_ok_next    = ok_reg;
            out_last_next  = (word_reg == psfp_pkg::LAST_IDX);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psfp_pkg::S_IDLE;
            count_reg     <= '0;
            prev_reg      <= 8'h00;
            hdr0_reg      <= 8'h00;
            hdr1_reg      <= 8'h00;
            len_hi_reg    <= 8'h00;
            len_lo_reg    <= 8'h00;
            acc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            prev_reg      <= prev_next;
            hdr0_reg      <= hdr0_next;
            hdr1_reg      <= hdr1_next;
            len_hi_reg    <= len_hi_next;
            len_lo_reg    <= len_lo_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pend_reg      <= pend_next;
        idx_reg       <= idx_next;
        last_reg      <= last_next;
        sum_reg       <= sum_next;
        hi_reg        <= hi_next;
        ok_reg        <= ok_next;
        word_reg      <= word_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_ok_reg    <= out_ok_next;
        out_last_reg  <= out_last_next;
    end

    assign bytes.ready       = (state_reg == psfp_pkg::S_IDLE);
    assign words.valid       = out_valid_reg;
    assign words.word_index  = out_index_reg;
    assign words.word_value  = out_value_reg;
    assign words.checksum_ok = out_ok_reg;
    assign words.last_word   = out_last_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(BUF_DEPTH))
        else $error("byte count beyond store depth");

    a_hdr_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes.valid && bytes.ready && hdr_pair) |=>
        (state_reg == psfp_pkg::S_HDR2) && (hdr0_reg == psfp_pkg::HDR_FIRST))
        else $error("header pair did not restart the frame");

    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psfp_pkg::S_SUM) |-> (idx_reg <= last_reg))
        else $error("sum index ran past frame span");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (words.valid && words.last_word) |-> (words.word_index == psfp_pkg::LAST_IDX))
        else $error("last flag on a word other than the checksum word");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (word_reg == psfp_pkg::LAST_IDX)) |=>
        (state_reg == psfp_pkg::S_IDLE))
        else $error("sequencer did not return to idle after the checksum word");

endmodule

FILE: bench/particulate_sensor_frame_parser_checker.sv
`timescale 1ns / 1ps

// Watches both channels, tracks the frame store from the accepted bytes and
// checks every delivered word against the words that frame should produce.
module particulate_sensor_frame_parser_checker
    import psfp_pkg::*;
#(
    parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    psfp_byte_if bytes,
    psfp_word_if words,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] value;
        logic        ck_ok;
        logic        last_flag;
    } frame_word_t;

    // Local copy of the parser state
    logic [7:0]  frame_mem [BUF_DEPTH];
    int          held;
    logic [7:0]  last_rx;
    frame_word_t expected_words [$];
    frame_word_t want;
    int          mismatch_total = 0;

    function automatic logic [15:0] word_at(input int pos);
        return {frame_mem[pos], frame_mem[pos + 1]};
    endfunction

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatch_total++;
    endtask

    // One received byte: header restart, overflow wrap, store, frame completion
    task automatic absorb_rx_byte(input logic [7:0] rx);
        logic [16:0] flen;
        logic [15:0] byte_sum;
        logic [15:0] ck_word;
        frame_word_t rec;
        if (last_rx == HDR_FIRST && rx == HDR_SECOND)
        begin
            frame_mem[0] = HDR_FIRST;
            held = 1;
        end
        else if (held >= BUF_DEPTH)
        begin
            held = 0;
        end
        if (held < BUF_DEPTH)
        begin
            frame_mem[held] = rx;
            held++;
        end
        last_rx = rx;

        if (held > 3)
        begin
            flen = {1'b0, frame_mem[2], frame_mem[3]};
            if (int'(flen) + 4 == held)
            begin
                held = 0;
                // bad header: frame is dropped silently
                if (frame_mem[0] == HDR_FIRST && frame_mem[1] == HDR_SECOND)
                begin
                    byte_sum = '0;
                    for (int i = 0; i < int'(flen) + 2 && i < BUF_DEPTH; i++)
                    begin
                        byte_sum += frame_mem[i];
                    end
                    ck_word = word_at(CK_POS);
                    for (int i = 0; i < WORD_COUNT; i++)
                    begin
                        rec.idx       = 4'(i);
                        rec.value     = word_at(WORD_BASE + 2 * i);
                        rec.ck_ok     = (byte_sum == ck_word);
                        rec.last_flag = (4'(i) == LAST_IDX);
                        expected_words.push_back(rec);
                    end
                end
            end
        end
    endtask

    // Sample both channels at each edge; outputs are published with NBAs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (frame_mem[i])
            begin
                frame_mem[i] = '0;
            end
            held    = 0;
            last_rx = '0;
            expected_words.delete();
        end
        else
        begin
            if (bytes.valid && bytes.ready)
            begin
                absorb_rx_byte(bytes.rx_byte);
            end
            if (words.valid && words.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    flag_mismatch($sformatf("word %0d = %h delivered with no frame pending",
                                            words.word_index, words.word_value));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (words.word_index !== want.idx)
                    begin
                        flag_mismatch($sformatf("word_index %0d, expected %0d",
                                                words.word_index, want.idx));
                    end
                    if (words.word_value !== want.value)
                    begin
                        flag_mismatch($sformatf("word %0d word_value %h, expected %h",
                                                want.idx, words.word_value, want.value));
                    end
                    if (words.checksum_ok !== want.ck_ok)
                    begin
                        flag_mismatch($sformatf("word %0d checksum_ok %b, expected %b",
                                                want.idx, words.checksum_ok, want.ck_ok));
                    end
                    if (words.last_word !== want.last_flag)
                    begin
                        flag_mismatch($sformatf("word %0d last_word %b, expected %b",
                                                want.idx, words.last_word, want.last_flag));
                    end
                end
            end
        end
        fail_count <= mismatch_total;
        pending    <= expected_words.size();
    end

endmodule

FILE: bench/particulate_sensor_frame_parser_top_test.sv
`timescale 1ns / 1ps

// Drives received bytes into the parser, takes the decoded words with random
// stalls, and gives the verdict from the checker's counts.
module particulate_sensor_frame_parser_top_test;
    import psfp_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int ITEM_TARGET  = 110;
    localparam int FULL_LEN     = CK_POS - 2;   // length field of a standard frame
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 200;
    localparam int RUN_LIMIT    = 400000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    psfp_byte_if byte_ch ();
    psfp_word_if word_ch ();

    int fail_count;
    int frame_words_pending;
    int unsigned cycle_count = 0;
    int unsigned words_taken = 0;
    bit          long_hold_done = 1'b0;

    logic [7:0] rx_stream [$];

    // Directed opening: bad header, short frame, doubled first header byte,
    // header restart in the middle of a frame
    logic [7:0] opening_bytes [25] = '{
        8'h00, 8'hFF, 8'h00, 8'h00,
        HDR_FIRST, HDR_SECOND, 8'h00, 8'h00,
        HDR_FIRST, HDR_FIRST, HDR_SECOND, 8'h00, 8'h02, 8'hAB, 8'hCD,
        HDR_FIRST, HDR_SECOND, 8'h00, 8'h1C, 8'h11,
        HDR_FIRST, HDR_SECOND, 8'h00, 8'h01, 8'h7F
    };

    particulate_sensor_frame_parser_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .bytes (byte_ch),
        .words (word_ch)
    );

    particulate_sensor_frame_parser_checker frame_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (byte_ch),
        .words      (word_ch),
        .fail_count (fail_count),
        .pending    (frame_words_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Header, length field and random body; a standard frame may get a valid checksum
    task automatic add_frame(input int unsigned flen, input bit seal);
        logic [7:0]  body [$];
        logic [15:0] sum;
        body = {HDR_FIRST, HDR_SECOND, 8'(flen >> 8), 8'(flen)};
        repeat (flen)
        begin
            body.push_back(8'($urandom));
        end
        if (seal && flen == FULL_LEN)
        begin
            sum = '0;
            for (int i = 0; i < CK_POS; i++)
            begin
                sum += body[i];
            end
            body[CK_POS]     = sum[15:8];
            body[CK_POS + 1] = sum[7:0];
        end
        rx_stream = {rx_stream, body};
    endtask

    // Byte sender, then end of run
    initial
    begin : byte_source
        int unsigned gap;
        int unsigned full_frames;
        int unsigned pick;
        logic [7:0]  len_hi;
        bit          steady;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= '0;
        steady      = 1'b0;
        full_frames = 0;

        foreach (opening_bytes[i])
        begin
            rx_stream.push_back(opening_bytes[i]);
        end

        // Length the store can never hold: runs into the overflow wrap
        len_hi = 8'($urandom);
        rx_stream.push_back(HDR_FIRST);
        rx_stream.push_back(HDR_SECOND);
        rx_stream.push_back(len_hi);
        rx_stream.push_back(len_hi == 0 ? 8'($urandom_range(61, 255)) : 8'($urandom));
        repeat (61)
        begin
            rx_stream.push_back(8'($urandom));
        end

        // Mostly well-formed frames, some noise and truncated frames
        while (rx_stream.size() < ITEM_TARGET || full_frames < 1)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                add_frame(FULL_LEN, full_frames == 0 || $urandom_range(0, 4) != 0);
                full_frames++;
            end
            else if (pick < 65)
            begin
                add_frame($urandom_range(0, FULL_LEN - 1), 1'b0);
            end
            else if (pick < 75)
            begin
                add_frame($urandom_range(FULL_LEN + 1, 60), 1'b0);
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    rx_stream.push_back($urandom_range(0, 3) == 0 ? HDR_FIRST : 8'($urandom));
                end
            end
            else
            begin
                rx_stream.push_back(HDR_FIRST);
                rx_stream.push_back(HDR_SECOND);
                repeat ($urandom_range(0, 3))
                begin
                    rx_stream.push_back(8'($urandom));
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rx_stream[i])
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                steady = !steady;
            end
            gap = steady ? 0 : $urandom_range(0, 14);
            if (gap > 0)
            begin
                byte_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_ch.valid   <= 1'b1;
            byte_ch.rx_byte <= rx_stream[i];
            do @(posedge clk); while (!byte_ch.ready);
        end
        byte_ch.valid <= 1'b0;

        // Let the checker publish the count from the last accepted byte
        @(posedge clk);
        while (frame_words_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && frame_words_pending == 0)
        begin
            $display("[particulate_sensor_frame_parser_top] OK");
        end
        else
        begin
            $display("[particulate_sensor_frame_parser_top] ERROR");
        end
        $finish;
    end

    // Word receiver with random stalls and one long hold-off
    initial
    begin : word_sink
        int unsigned pause;
        bit          steady;
        word_ch.ready <= 1'b0;
        pause  = 0;
        steady = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (pause > 0)
            begin
                word_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            word_ch.ready <= 1'b1;
            do @(posedge clk); while (!word_ch.valid);
            words_taken++;
            if ($urandom_range(0, 15) == 0)
            begin
                steady = !steady;
            end
            pause = steady ? 0 : $urandom_range(0, 14);
            if (!long_hold_done && words_taken == 5)
            begin
                pause          = LONG_HOLD;
                long_hold_done = 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[particulate_sensor_frame_parser_top] ERROR");
        $finish;
    end

endmodule
